/* sv/ptrs_pkg.sv */
`default_nettype none
package ptrs_pkg;

  localparam int NumTasksDef = 8;
  localparam int DataW       = 32;

  typedef enum logic [1:0] {
    FUNC_REG      = 2'd0,
    FUNC_TICK     = 2'd1,
    FUNC_DISPATCH = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] task_period;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  released_mask;
    logic        accepted;
    logic [3:0]  task_count;
    logic [31:0] hyperperiod_now;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,      // issue table read
    ST_RDW,     // read data arrives
    ST_MOD,     // divider busy (tick: cnt % p)
    ST_GCD,     // divider busy (gcd step)
    ST_QUOT,    // divider busy (acc / g)
    ST_MUL,     // product
    ST_OUT
  } state_t;

  // divider request / reply
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

/* sv/ptrs_ram.sv */
`default_nettype none
module ptrs_ram #(
  parameter int Width = 32,
  parameter int Depth = 8
) (
  input  wire                                          clk,
  input  wire                                          we,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr,
  input  wire [Width-1:0]                              wdata,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr,
  output logic [Width-1:0]                             rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/ptrs_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle. Divide by zero gives
// quotient all ones and remainder = numerator (never used by the caller).
module ptrs_div (
  input  wire                clk,
  input  wire                rst_n,
  input  ptrs_pkg::div_req_t req,
  output ptrs_pkg::div_rsp_t rsp
);
  logic [31:0] quot_r, quot_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  always_comb begin
    shifted  = {rem_r, quot_r[31]};
    diff     = shifted - {1'b0, den_r};
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quot_nxt = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt  = diff[31:0];
        quot_nxt = {quot_r[30:0], 1'b1};
      end else begin
        rem_nxt  = shifted[31:0];
        quot_nxt = {quot_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r;
endmodule
`default_nettype wire

/* sv/periodic_task_release_scheduler_unit.sv */
`default_nettype none
// Channel | Ports                        | Payload
// input   | in_valid, in_stall, in_data  | ptrs_pkg::in_item_t (func, task_period)
// result  | out_valid, out_stall, out_data | ptrs_pkg::out_item_t
//
// One item at a time. Dispatch and unused codes pass through ST_RD and
// ST_OUT only. Tick: one 32-step divide per stored task with a nonzero
// period, none for a zero period. Register: per stored task up to about
// 46 Euclid divides plus one for the quotient, all of them run on the
// shared serial divider.
// Reset (rst_n low, synchronous) clears count, counter, hyperperiod, flags.
// A result waits in the output register under out_stall; in_stall is high
// while an item is in work, also while its result waits to be placed.
module periodic_task_release_scheduler_unit #(
  parameter int NumTasks = ptrs_pkg::NumTasksDef
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  ptrs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output ptrs_pkg::out_item_t  out_data
);
  localparam int AW = (NumTasks > 1) ? $clog2(NumTasks) : 1;
  localparam int CW = $clog2(NumTasks + 1);
  localparam int MW = (NumTasks < 8) ? NumTasks : 8;

  ptrs_pkg::state_t state_r, state_nxt;

  logic [1:0]          func_r, func_nxt;
  logic [31:0]         per_r, per_nxt;
  logic [CW-1:0]       used_r, used_nxt;
  logic [31:0]         tick_r, tick_nxt;
  logic [31:0]         hyp_r, hyp_nxt;
  logic [NumTasks-1:0] flags_r, flags_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [31:0]         acc_r, acc_nxt;   // running LCM
  logic [31:0]         p_r, p_nxt;       // current period
  logic [31:0]         ga_r, ga_nxt;     // euclid a
  logic [31:0]         gb_r, gb_nxt;     // euclid b
  logic                acc_ok_r, acc_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  ptrs_pkg::out_item_t out_r, out_nxt;
  logic                fwd_r, fwd_nxt;   // read hit the entry written that cycle
  logic [31:0]         rd_val;

  // period table
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;

  ptrs_ram #(.Width(32), .Depth(NumTasks)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(per_r),
    .raddr(raddr), .rdata(rdata)
  );

  ptrs_pkg::div_req_t dreq;
  ptrs_pkg::div_rsp_t drsp;
  ptrs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign raddr = idx_r[AW-1:0];
  assign waddr = used_r[AW-1:0];

  // forward the new period when it is read in the cycle it is written
  assign fwd_nxt = we && (waddr == raddr);
  assign rd_val  = fwd_r ? per_r : rdata;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptrs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = ptrs_pkg::ST_RD;
      end
      ptrs_pkg::ST_RD: begin
        if (func_r == ptrs_pkg::FUNC_REG || func_r == ptrs_pkg::FUNC_TICK) begin
          if (idx_r >= used_nxt) state_nxt = ptrs_pkg::ST_OUT;
          else                   state_nxt = ptrs_pkg::ST_RDW;
        end else begin
          state_nxt = ptrs_pkg::ST_OUT;
        end
      end
      ptrs_pkg::ST_RDW: begin
        if (func_r == ptrs_pkg::FUNC_TICK) begin
          state_nxt = (rd_val == '0) ? ptrs_pkg::ST_RD : ptrs_pkg::ST_MOD;
        end else if (acc_r == '0 || rd_val == '0) begin
          state_nxt = ptrs_pkg::ST_RD;
        end else begin
          state_nxt = ptrs_pkg::ST_GCD;
        end
      end
      ptrs_pkg::ST_MOD: if (drsp.done) state_nxt = ptrs_pkg::ST_RD;
      ptrs_pkg::ST_GCD: begin
        if (drsp.done && drsp.rem == '0) state_nxt = ptrs_pkg::ST_QUOT;
      end
      ptrs_pkg::ST_QUOT: if (drsp.done) state_nxt = ptrs_pkg::ST_MUL;
      ptrs_pkg::ST_MUL:  state_nxt = ptrs_pkg::ST_RD;
      ptrs_pkg::ST_OUT:  if (!out_valid_r || !out_stall) state_nxt = ptrs_pkg::ST_IDLE;
      default:           state_nxt = ptrs_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    func_nxt      = func_r;
    per_nxt       = per_r;
    used_nxt      = used_r;
    tick_nxt      = tick_r;
    hyp_nxt       = hyp_r;
    flags_nxt     = flags_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    p_nxt         = p_r;
    ga_nxt        = ga_r;
    gb_nxt        = gb_r;
    acc_ok_nxt    = acc_ok_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    dreq.start    = 1'b0;
    dreq.num      = '0;
    dreq.den      = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    case (state_r)
      ptrs_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_data.func;
          per_nxt    = in_data.task_period;
          idx_nxt    = '0;
          acc_nxt    = '0;
          acc_ok_nxt = 1'b0;
        end
      end
      ptrs_pkg::ST_RD: begin
        if (idx_r == '0) begin
          // first visit: item-level updates
          case (func_r)
            ptrs_pkg::FUNC_REG: begin
              if (used_r < CW'(NumTasks)) begin
                we         = 1'b1;
                used_nxt   = used_r + 1'b1;
                acc_ok_nxt = 1'b1;
              end
            end
            ptrs_pkg::FUNC_TICK: begin
              if (tick_r == hyp_r) tick_nxt = '0;
            end
            default: ;
          endcase
        end
        if (idx_r >= used_nxt && func_r == ptrs_pkg::FUNC_REG) hyp_nxt = acc_r;
      end
      ptrs_pkg::ST_RDW: begin
        p_nxt = rd_val;
        if (func_r == ptrs_pkg::FUNC_TICK) begin
          if (rd_val != '0) begin
            dreq.start = 1'b1;
            dreq.num   = tick_r;
            dreq.den   = rd_val;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (acc_r == '0) begin
          acc_nxt = rd_val;
          idx_nxt = idx_r + 1'b1;
        end else if (rd_val == '0) begin
          // gcd(acc,0)=acc; acc/acc*0 = 0
          acc_nxt = '0;
          idx_nxt = idx_r + 1'b1;
        end else begin
          // euclid(a=acc, b=p): b % a
          ga_nxt     = acc_r;
          dreq.start = 1'b1;
          dreq.num   = rd_val;
          dreq.den   = acc_r;
        end
      end
      ptrs_pkg::ST_MOD: begin
        if (drsp.done) begin
          if (drsp.rem == '0) flags_nxt = flags_r | (NumTasks'(1) << idx_r[AW-1:0]);
          idx_nxt = idx_r + 1'b1;
        end
      end
      ptrs_pkg::ST_GCD: begin
        if (drsp.done) begin
          if (drsp.rem == '0) begin
            // gcd is ga_r
            dreq.start = 1'b1;
            dreq.num   = acc_r;
            dreq.den   = ga_r;
          end else begin
            ga_nxt     = drsp.rem;
            gb_nxt     = ga_r;
            dreq.start = 1'b1;
            dreq.num   = ga_r;
            dreq.den   = drsp.rem;
          end
        end
      end
      ptrs_pkg::ST_QUOT: begin
        if (drsp.done) gb_nxt = drsp.quot;
      end
      ptrs_pkg::ST_MUL: begin
        acc_nxt = gb_r * p_r;
        idx_nxt = idx_r + 1'b1;
      end
      ptrs_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_nxt.accepted      = acc_ok_r;
          out_nxt.task_count    = 4'(used_r);
          out_nxt.hyperperiod_now = hyp_r;
          out_nxt.released_mask = '0;
          case (func_r)
            ptrs_pkg::FUNC_TICK: begin
              out_nxt.released_mask = 8'(flags_r[MW-1:0]);
              tick_nxt = tick_r + 32'd1;
            end
            ptrs_pkg::FUNC_DISPATCH: begin
              out_nxt.released_mask = 8'(flags_r[MW-1:0]);
              flags_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptrs_pkg::ST_IDLE;
      used_r      <= '0;
      tick_r      <= '0;
      hyp_r       <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      tick_r      <= tick_nxt;
      hyp_r       <= hyp_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_r       <= fwd_nxt;
    end
    func_r   <= func_nxt;
    per_r    <= per_nxt;
    idx_r    <= idx_nxt;
    acc_r    <= acc_nxt;
    p_r      <= p_nxt;
    ga_r     <= ga_nxt;
    gb_r     <= gb_nxt;
    acc_ok_r <= acc_ok_nxt;
    out_r    <= out_nxt;
  end

  assign in_stall  = (state_r != ptrs_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(NumTasks)) else $error("task count beyond table");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptrs_pkg::ST_OUT && !out_stall) |=> out_valid)
    else $error("result not presented");
  a_dispatch_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ptrs_pkg::ST_OUT && func_r == ptrs_pkg::FUNC_DISPATCH &&
     (!out_valid_r || !out_stall)) |=> flags_r == '0)
    else $error("flags not cleared on dispatch");
`endif
endmodule
`default_nettype wire

/* dv/periodic_task_release_scheduler_unit_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module periodic_task_release_scheduler_unit_tb;

  localparam int NTasks = 8;
  localparam int WatchdogLimit = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ptrs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ptrs_pkg::out_item_t out_data;

  periodic_task_release_scheduler_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler shadow state
  logic [31:0] sh_period [NTasks];
  logic [7:0] sh_flags;
  int unsigned sh_used;
  logic [31:0] sh_tick;
  logic [31:0] sh_hyper;

  ptrs_pkg::in_item_t pending_items[$];
  ptrs_pkg::out_item_t expected_results[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit hold_sender = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;

  function automatic logic [31:0] gcd32(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    while (a != 0) begin
      t = a;
      a = b % a;
      b = t;
    end
    return b;
  endfunction

  // fold of wrapping LCMs over the stored periods
  function automatic logic [31:0] hyperperiod_of();
    logic [31:0] h;
    h = 0;
    for (int i = 0; i < sh_used; i++) begin
      if (h == 0) h = sh_period[i];
      else h = (h / gcd32(h, sh_period[i])) * sh_period[i];
    end
    return h;
  endfunction

  // advance shadow state by one transfer and return the expected result
  function automatic ptrs_pkg::out_item_t schedule_item(ptrs_pkg::in_item_t it);
    ptrs_pkg::out_item_t r;
    r = '0;
    case (ptrs_pkg::func_t'(it.func))
      ptrs_pkg::FUNC_REG: begin
        if (sh_used < NTasks) begin
          sh_period[sh_used] = it.task_period;
          sh_used++;
          r.accepted = 1'b1;
        end
        sh_hyper = hyperperiod_of();
      end
      ptrs_pkg::FUNC_TICK: begin
        if (sh_tick == sh_hyper) sh_tick = 0;
        for (int i = 0; i < sh_used; i++)
          if (sh_period[i] != 0 && (sh_tick % sh_period[i]) == 0) sh_flags[i] = 1'b1;
        sh_tick++;
        r.released_mask = sh_flags;
      end
      ptrs_pkg::FUNC_DISPATCH: begin
        r.released_mask = sh_flags;
        sh_flags = '0;
      end
      default: ;
    endcase
    r.task_count = sh_used[3:0];
    r.hyperperiod_now = sh_hyper;
    return r;
  endfunction

  function automatic ptrs_pkg::in_item_t mk(ptrs_pkg::func_t f, logic [31:0] p);
    ptrs_pkg::in_item_t it;
    it.func = f;
    it.task_period = p;
    return it;
  endfunction

  function automatic logic [31:0] rand_period();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // sender: bursts and gaps; holds a payload until it is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(schedule_item(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (burst_left == 0 && $urandom_range(0, 3) == 0) begin
          burst_left <= $urandom_range(1, 8);
          gap_left <= $urandom_range(1, 6);
          in_valid <= 1'b0;
        end else if (hold_sender || pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: own stall pattern, checks each transfer against the oldest expectation
  always @(posedge clk) begin
    ptrs_pkg::out_item_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (e.released_mask !== out_data.released_mask) begin
            $display("%0t: released_mask exp %h got %h", $time, e.released_mask,
                     out_data.released_mask);
            errors++;
          end
          if (e.accepted !== out_data.accepted) begin
            $display("%0t: accepted exp %b got %b", $time, e.accepted, out_data.accepted);
            errors++;
          end
          if (e.task_count !== out_data.task_count) begin
            $display("%0t: task_count exp %0d got %0d", $time, e.task_count,
                     out_data.task_count);
            errors++;
          end
          if (e.hyperperiod_now !== out_data.hyperperiod_now) begin
            $display("%0t: hyperperiod exp %h got %h", $time, e.hyperperiod_now,
                     out_data.hyperperiod_now);
            errors++;
          end
        end
      end
      out_stall <= ($time / 700) % 3 == 0 ? 1'b0 : ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic sequence_phase(int n);
    pending_items.push_back(mk(ptrs_pkg::FUNC_DISPATCH, 0));
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0, 1: pending_items.push_back(mk(ptrs_pkg::FUNC_REG, rand_period()));
        2, 3: pending_items.push_back(mk(ptrs_pkg::FUNC_DISPATCH, $urandom()));
        4: pending_items.push_back(mk(ptrs_pkg::FUNC_NONE, $urandom()));
        default: pending_items.push_back(mk(ptrs_pkg::FUNC_TICK, $urandom()));
      endcase
    end
  endtask

  initial begin
    sh_flags = '0;
    sh_used = 0;
    sh_tick = '0;
    sh_hyper = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero and huge periods, overflowing LCM, full table, all codes
    pending_items.push_back(mk(ptrs_pkg::FUNC_TICK, 32'hFFFF_FFFF));
    pending_items.push_back(mk(ptrs_pkg::FUNC_NONE, 32'hFFFF_FFFF));
    pending_items.push_back(mk(ptrs_pkg::FUNC_REG, 32'd2));
    pending_items.push_back(mk(ptrs_pkg::FUNC_REG, 32'd3));
    for (int k = 0; k < 7; k++) pending_items.push_back(mk(ptrs_pkg::FUNC_TICK, 0));
    pending_items.push_back(mk(ptrs_pkg::FUNC_DISPATCH, 32'hFFFF_FFFF));
    pending_items.push_back(mk(ptrs_pkg::FUNC_REG, 32'd0));
    pending_items.push_back(mk(ptrs_pkg::FUNC_REG, 32'hFFFF_FFFF));
    pending_items.push_back(mk(ptrs_pkg::FUNC_REG, 32'hFFFF_FFFE));
    pending_items.push_back(mk(ptrs_pkg::FUNC_REG, 32'd1));
    pending_items.push_back(mk(ptrs_pkg::FUNC_REG, 32'h8000_0000));
    pending_items.push_back(mk(ptrs_pkg::FUNC_REG, 32'd5));
    pending_items.push_back(mk(ptrs_pkg::FUNC_REG, 32'd7));
    pending_items.push_back(mk(ptrs_pkg::FUNC_TICK, 0));
    pending_items.push_back(mk(ptrs_pkg::FUNC_DISPATCH, 0));

    // pause until the block has drained; the step lets the last pop reach in_valid
    wait (pending_items.size() == 0);
    hold_sender = 1'b1;
    #1;
    wait (expected_results.size() == 0 && !in_valid);
    hold_sender = 1'b0;

    // table stays full here; a fresh table needs reset, so keep exercising ticks
    sequence_phase(120);
    wait (pending_items.size() == 0);
    #1;
    wait (!in_valid && expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
